/* rtl/timestamp_text_to_unix_epoch_top_defines.svh */
// ----------------------------------------------------------------------------
// Timestamp-to-epoch assertion macros
// Concurrent assertion wrappers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_TEXT_TO_UNIX_EPOCH_TOP_DEFINES_SVH
`define TIMESTAMP_TEXT_TO_UNIX_EPOCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define TTUE_ASSERT_RST(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);
`define TTUE_ASSERT_ANY(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TTUE_ASSERT_RST(lbl, clk_i, rstn_i, prop, msg)
`define TTUE_ASSERT_ANY(lbl, clk_i, prop, msg)
`endif

`endif

/* rtl/ttue_pkg.sv */
// ----------------------------------------------------------------------------
// Timestamp-to-epoch package
// Shared types, codes and constants of the timestamp parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ttue_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned CFG_IDX_W   = 4;
	localparam int unsigned YEAR_CFG_W  = 12;

	localparam logic [4:0] TS_LEN = 5'd19;

	localparam logic [YEAR_CFG_W-1:0] MIN_YEAR_RST = 12'd2025;
	localparam logic [YEAR_CFG_W-1:0] MAX_YEAR_RST = 12'd2099;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 4'd1;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_YEAR  = 3'd2,
		ST_DATE  = 3'd3,
		ST_TIME  = 3'd4,
		ST_EPOCH = 3'd5
	} status_t;

	typedef struct packed {
		logic        too_short;
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} parse_rec_t;

	// Day of year at the first of a month, year starting in March.
	function automatic logic [8:0] month_offset(input logic [3:0] mp);
		logic [8:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/ttue_front.sv */
// ----------------------------------------------------------------------------
// Timestamp-to-epoch front end
// Takes one character a beat, builds the field values and queues a record
// at the last character.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timestamp_text_to_unix_epoch_top_defines.svh"

module ttue_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         char_byte,
	input  wire logic               last_char,
	input  wire logic               q_full,
	output logic                    push,
	output ttue_pkg::parse_rec_t    rec
);
	import ttue_pkg::*;

	typedef enum logic [2:0] {F_NONE, F_YEAR, F_MON, F_DAY, F_HOUR, F_MIN, F_SEC} field_t;

	logic [4:0]  pos_q, pos_n;
	logic        stop_q, stop_n;
	logic [13:0] year_q, year_n;
	logic [6:0]  mon_q, mon_n, day_q, day_n, hour_q, hour_n, min_q, min_n, sec_q, sec_n;
	logic        fire, digit, fstart, stop_eff, take;
	field_t      sel;

	function automatic logic [13:0] mul10add(input logic [13:0] acc, input logic [3:0] d);
		return (acc << 3) + (acc << 1) + {10'b0, d};
	endfunction

	assign in_ready = ~q_full;
	assign fire     = in_valid & in_ready;
	assign digit    = (char_byte >= 8'd48) && (char_byte <= 8'd57);

	always_comb begin
		unique case (pos_q)
			5'd0, 5'd1, 5'd2, 5'd3: sel = F_YEAR;
			5'd5, 5'd6:             sel = F_MON;
			5'd8, 5'd9:             sel = F_DAY;
			5'd11, 5'd12:           sel = F_HOUR;
			5'd14, 5'd15:           sel = F_MIN;
			5'd17, 5'd18:           sel = F_SEC;
			default:                sel = F_NONE;
		endcase
	end

	assign fstart = (pos_q == 5'd0) || (pos_q == 5'd5) || (pos_q == 5'd8) ||
		(pos_q == 5'd11) || (pos_q == 5'd14) || (pos_q == 5'd17);
	assign stop_eff = stop_q & ~fstart;
	assign take     = ~stop_eff & digit;

	always_comb begin
		pos_n  = pos_q;
		stop_n = stop_q;
		year_n = year_q;
		mon_n  = mon_q;
		day_n  = day_q;
		hour_n = hour_q;
		min_n  = min_q;
		sec_n  = sec_q;
		if (pos_q < TS_LEN) begin
			pos_n  = pos_q + 5'd1;
			stop_n = stop_eff;
			if (sel != F_NONE) begin
				stop_n = stop_eff | ~digit;
			end
			if (take) begin
				unique case (sel)
					F_YEAR:  year_n = mul10add(year_q, char_byte[3:0]);
					F_MON:   mon_n  = 7'(mul10add({7'b0, mon_q}, char_byte[3:0]));
					F_DAY:   day_n  = 7'(mul10add({7'b0, day_q}, char_byte[3:0]));
					F_HOUR:  hour_n = 7'(mul10add({7'b0, hour_q}, char_byte[3:0]));
					F_MIN:   min_n  = 7'(mul10add({7'b0, min_q}, char_byte[3:0]));
					F_SEC:   sec_n  = 7'(mul10add({7'b0, sec_q}, char_byte[3:0]));
					default: ;
				endcase
			end
		end
	end

	assign push          = fire & last_char;
	assign rec.too_short = pos_n < TS_LEN;
	assign rec.year      = year_n;
	assign rec.month     = mon_n;
	assign rec.day       = day_n;
	assign rec.hour      = hour_n;
	assign rec.minute    = min_n;
	assign rec.second    = sec_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			stop_q <= 1'b0;
			year_q <= '0;
			mon_q  <= '0;
			day_q  <= '0;
			hour_q <= '0;
			min_q  <= '0;
			sec_q  <= '0;
		end else if (fire) begin
			if (last_char) begin
				pos_q  <= '0;
				stop_q <= 1'b0;
				year_q <= '0;
				mon_q  <= '0;
				day_q  <= '0;
				hour_q <= '0;
				min_q  <= '0;
				sec_q  <= '0;
			end else begin
				pos_q  <= pos_n;
				stop_q <= stop_n;
				year_q <= year_n;
				mon_q  <= mon_n;
				day_q  <= day_n;
				hour_q <= hour_n;
				min_q  <= min_n;
				sec_q  <= sec_n;
			end
		end
	end

	`TTUE_ASSERT_RST(a_front_clear, clk, arst_n, (fire && last_char) |=> (pos_q == 5'd0), "position not cleared after last beat")
	`TTUE_ASSERT_ANY(a_front_push, clk, push |-> !q_full, "record pushed into full queue")

endmodule

`default_nettype wire

/* rtl/ttue_fifo.sv */
// ----------------------------------------------------------------------------
// Timestamp-to-epoch record queue
// Short queue of parsed records between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timestamp_text_to_unix_epoch_top_defines.svh"

module ttue_fifo #(
	parameter int unsigned Depth = ttue_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ttue_pkg::parse_rec_t wdata,
	input  wire logic                 pop,
	output ttue_pkg::parse_rec_t      rdata,
	output logic                      full,
	output logic                      empty
);
	import ttue_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	parse_rec_t      mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full  = (cnt_q == FullCnt);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	`TTUE_ASSERT_RST(a_fifo_pop, clk, arst_n, pop |-> (cnt_q != '0), "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/ttue_back.sv */
// ----------------------------------------------------------------------------
// Timestamp-to-epoch back end
// Range checks, days-from-civil and second count in a stalling pipeline
// with a registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "timestamp_text_to_unix_epoch_top_defines.svh"

module ttue_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [11:0]          min_year,
	input  wire logic [11:0]          max_year,
	input  wire ttue_pkg::parse_rec_t rec,
	input  wire logic                 q_empty,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [2:0]                status,
	output logic [31:0]               epoch_seconds
);
	import ttue_pkg::*;

	localparam logic signed [21:0] DaysBias = 22'sd865565;
	localparam logic signed [38:0] MaxEpoch = 39'sd4294967295;

	logic en;

	// head checks
	status_t    st_pre;
	logic       feb;
	logic [12:0] y_pre;
	logic [6:0] mp;
	logic [8:0] doy_pre;

	logic        v_s1, v_s2, v_s3, v_s4, out_valid_q;
	status_t     st_s1, st_s2, st_s3, st_s4, status_q;
	logic [12:0] y_s1, y_s2;
	logic [8:0]  doy_s1, doy_s2;
	logic [4:0]  hr_s1;
	logic [5:0]  mi_s1, se_s1;
	logic [25:0] p100_s2;
	logic [21:0] y365_s2;
	logic [16:0] tod_s2, tod_s3, tod_s4;
	logic signed [21:0] days_s3;
	logic signed [38:0] dsec_s4;
	logic [31:0] epoch_q;

	logic [5:0]  q100;
	logic [21:0] usum;
	logic signed [38:0] e_sum;
	status_t     st_fin;
	logic [31:0] ep_fin;

	assign en  = ~out_valid_q | out_ready;
	assign pop = en & ~q_empty;

	always_comb begin
		priority if (rec.too_short) begin
			st_pre = ST_SHORT;
		end else if (rec.year < {2'b0, min_year} || rec.year > {2'b0, max_year}) begin
			st_pre = ST_YEAR;
		end else if (rec.month == 7'd0 || rec.month > 7'd12 ||
				rec.day == 7'd0 || rec.day > 7'd31) begin
			st_pre = ST_DATE;
		end else if (rec.hour > 7'd23 || rec.minute > 7'd59 || rec.second > 7'd59) begin
			st_pre = ST_TIME;
		end else begin
			st_pre = ST_OK;
		end
	end

	// shift the year by one era so it stays non-negative
	assign feb     = rec.month <= 7'd2;
	assign y_pre   = {1'b0, rec.year[11:0]} + 13'd400 - {12'b0, feb};
	assign mp      = feb ? rec.month + 7'd9 : rec.month - 7'd3;
	assign doy_pre = month_offset(mp[3:0]) + {4'b0, rec.day[4:0]} - 9'd1;

	assign q100  = p100_s2[24:19];
	assign usum  = y365_s2 + {11'b0, y_s2[12:2]} + {18'b0, q100[5:2]} + {13'b0, doy_s2}
		- {16'b0, q100};
	assign e_sum = dsec_s4 + $signed({22'b0, tod_s4});

	always_comb begin
		st_fin = st_s4;
		ep_fin = '0;
		if (st_s4 == ST_OK) begin
			priority if (e_sum <= 39'sd0) begin
				st_fin = ST_EPOCH;
			end else if (e_sum > MaxEpoch) begin
				ep_fin = '1;
			end else begin
				ep_fin = e_sum[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= ~q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1    <= st_pre;
			y_s1     <= y_pre;
			doy_s1   <= doy_pre;
			hr_s1    <= rec.hour[4:0];
			mi_s1    <= rec.minute[5:0];
			se_s1    <= rec.second[5:0];
			st_s2    <= st_s1;
			y_s2     <= y_s1;
			doy_s2   <= doy_s1;
			p100_s2  <= {13'b0, y_s1} * 26'd5243;
			y365_s2  <= {9'b0, y_s1} * 22'd365;
			tod_s2   <= {12'b0, hr_s1} * 17'd3600 + {11'b0, mi_s1} * 17'd60 + {11'b0, se_s1};
			st_s3    <= st_s2;
			tod_s3   <= tod_s2;
			days_s3  <= $signed(usum) - DaysBias;
			st_s4    <= st_s3;
			tod_s4   <= tod_s3;
			dsec_s4  <= days_s3 * $signed(18'd86400);
			status_q <= st_fin;
			epoch_q  <= ep_fin;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign epoch_seconds = epoch_q;

	`TTUE_ASSERT_RST(a_back_zero, clk, arst_n, (out_valid_q && status_q != ST_OK) |-> (epoch_q == 32'd0), "epoch not zero on error status")
	`TTUE_ASSERT_RST(a_back_pop, clk, arst_n, pop |=> v_s1, "popped record lost before first stage")

endmodule

`default_nettype wire

/* rtl/timestamp_text_to_unix_epoch_top.sv */
// ----------------------------------------------------------------------------
// Timestamp text to Unix epoch
// Parses "YYYY-MM-DD HH:MM:SS" UTC text a character a beat and returns a
// status and the seconds since 1970-01-01 at the last character.
//
//   channel | signals                                     | direction
//   in      | in_valid, in_ready, char_byte, last_char    | into block
//   out     | out_valid, out_ready, status, epoch_seconds | out of block
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | into block
//
// One character is taken every cycle while the record queue is not full;
// the front parser holds one string. A record passes from the queue through
// a four-stage back pipeline and the output register.
// Reset clears the parser, queue and pipeline and loads years 2025..2099.
// A stalled output holds the back pipeline; the front keeps taking beats
// until the record queue fills, then drops in_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_text_to_unix_epoch_top #(
	parameter int unsigned QueueDepth = ttue_pkg::QUEUE_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       char_byte,
	input  wire logic                             last_char,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [2:0]                            status,
	output logic [31:0]                           epoch_seconds,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [ttue_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ttue_pkg::YEAR_CFG_W-1:0]  cfg_data
);
	import ttue_pkg::*;

	logic [YEAR_CFG_W-1:0] min_year_q, max_year_q;
	logic       push, pop, q_full, q_empty;
	parse_rec_t rec_in, rec_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MIN_YEAR) begin
				min_year_q <= cfg_data;
			end else if (cfg_index == REG_MAX_YEAR) begin
				max_year_q <= cfg_data;
			end
		end
	end

	ttue_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_byte (char_byte),
		.last_char (last_char),
		.q_full    (q_full),
		.push      (push),
		.rec       (rec_in)
	);

	ttue_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (rec_in),
		.pop    (pop),
		.rdata  (rec_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	ttue_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_year      (min_year_q),
		.max_year      (max_year_q),
		.rec           (rec_out),
		.q_empty       (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.epoch_seconds (epoch_seconds)
	);

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timestamp-to-epoch parser testbench
// Sends timestamp text one character a beat and checks each status and epoch
// result in order against the table or a cycle-free parser model in this
// module. A short table of fixed strings comes first, then random strings
// in several year-window settings, with bursty input and a stalling output.
// ----------------------------------------------------------------------------

module tb_top;
	import ttue_pkg::*;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_PAUSE  = 12;
	localparam int unsigned END_PAUSE    = 24;
	localparam int unsigned PHASE_BEATS  = 90;
	localparam int unsigned N_CASES      = 21;
	localparam int unsigned N_SET_PHASES = 5;
	localparam int unsigned N_PHASES     = 7;

	typedef struct {
		status_t     st;
		logic [31:0] secs;
	} stamp_t;

	typedef struct {
		string       txt;
		int unsigned lo_y;
		int unsigned hi_y;
		bit          fixed;
		status_t     st;
		logic [31:0] secs;
	} stamp_case_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_HALF,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           char_byte = '0;
	logic                 last_char = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [2:0]           status;
	logic [31:0]          epoch_seconds;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [YEAR_CFG_W-1:0] cfg_data = '0;

	// parser model state
	logic [YEAR_CFG_W-1:0] lo_year = MIN_YEAR_RST;
	logic [YEAR_CFG_W-1:0] hi_year = MAX_YEAR_RST;
	logic [4:0]  pos = '0;
	logic [13:0] yr = '0;
	logic [6:0]  mo = '0;
	logic [6:0]  dy = '0;
	logic [6:0]  hr = '0;
	logic [6:0]  mi = '0;
	logic [6:0]  se = '0;
	logic        stopped = 1'b0;

	stamp_t       epoch_q[$];
	stamp_t       front_stamp;
	logic [7:0]   stamp_text[$];
	int unsigned  miss_count = 0;
	int unsigned  beats_sent = 0;
	int unsigned  burst_left = 0;
	int unsigned  idle_cycles = 0;
	bit           hold_req = 1'b0;
	bit           hold_done = 1'b0;
	int unsigned  hold_left = 0;
	rx_mode_t     rx_mode = RX_FREE;
	int unsigned  rx_left = 0;

	int unsigned phase_lo [N_SET_PHASES] = '{2025, 1970, 2099, 1970, 2099};
	int unsigned phase_hi [N_SET_PHASES] = '{2099, 2099, 1970, 1970, 2099};

	stamp_case_t stamp_cases [N_CASES] = '{
		'{"2025-01-01 00:00:00", 2025, 2099, 1'b1, ST_OK,    32'd1735689600},
		'{"2099-12-31 23:59:59", 2025, 2099, 1'b1, ST_OK,    32'd4102444799},
		'{"2024-12-31 23:59:59", 2025, 2099, 1'b1, ST_YEAR,  32'd0},
		'{"2025-00-10 12:00:00", 2025, 2099, 1'b1, ST_DATE,  32'd0},
		'{"2025-05-32 12:00:00", 2025, 2099, 1'b1, ST_DATE,  32'd0},
		'{"2025-05-10 24:00:00", 2025, 2099, 1'b1, ST_TIME,  32'd0},
		'{"2025-05-10 23:60:00", 2025, 2099, 1'b1, ST_TIME,  32'd0},
		'{"2025-05-10 23:59:60", 2025, 2099, 1'b1, ST_TIME,  32'd0},
		'{"2025-0",              2025, 2099, 1'b1, ST_SHORT, 32'd0},
		'{"7",                   2025, 2099, 1'b1, ST_SHORT, 32'd0},
		'{"2025-02-31 06:07:08", 2025, 2099, 1'b0, ST_OK,    32'd0},
		'{"2030-7/-04 1a:02:0z", 2025, 2099, 1'b0, ST_OK,    32'd0},
		'{"2040-03-01 00:00:00 trailing", 2025, 2099, 1'b0, ST_OK, 32'd0},
		'{"+2050-01-01 00:00:0", 2025, 2099, 1'b1, ST_YEAR,  32'd0},
		'{" 2050-01-01 00:00:00", 2025, 2099, 1'b1, ST_YEAR, 32'd0},
		'{"1970-01-01 00:00:00", 1970, 2099, 1'b1, ST_EPOCH, 32'd0},
		'{"1970-01-01 00:00:01", 1970, 2099, 1'b1, ST_OK,    32'd1},
		'{"2038-01-19 03:14:07", 1970, 2099, 1'b1, ST_OK,    32'd2147483647},
		'{"2000-02-29 12:34:56", 1970, 2099, 1'b0, ST_OK,    32'd0},
		'{"2050-06-15 12:00:00", 2099, 1970, 1'b1, ST_YEAR,  32'd0},
		'{"1970-12-31 23:59:59", 1970, 1970, 1'b0, ST_OK,    32'd0}
	};

	timestamp_text_to_unix_epoch_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_byte     (char_byte),
		.last_char     (last_char),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.epoch_seconds (epoch_seconds),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic void clear_fields();
		pos = '0;
		yr = '0;
		mo = '0;
		dy = '0;
		hr = '0;
		mi = '0;
		se = '0;
		stopped = 1'b0;
	endfunction

	function automatic void absorb(input logic [7:0] c);
		logic [3:0] d;
		bit take;
		bit in_field;
		d = 4'(c - 8'h30);
		if (pos == 5'd0 || pos == 5'd5 || pos == 5'd8 || pos == 5'd11 || pos == 5'd14 ||
				pos == 5'd17)
			stopped = 1'b0;
		in_field = !(pos == 5'd4 || pos == 5'd7 || pos == 5'd10 || pos == 5'd13 ||
				pos == 5'd16);
		take = !stopped && c >= 8'h30 && c <= 8'h39;
		if (in_field && !take)
			stopped = 1'b1;
		if (in_field && take) begin
			case (pos)
				5'd0, 5'd1, 5'd2, 5'd3: yr = 14'(yr * 10 + d);
				5'd5, 5'd6:             mo = 7'(mo * 10 + d);
				5'd8, 5'd9:             dy = 7'(dy * 10 + d);
				5'd11, 5'd12:           hr = 7'(hr * 10 + d);
				5'd14, 5'd15:           mi = 7'(mi * 10 + d);
				default:                se = 7'(se * 10 + d);
			endcase
		end
	endfunction

	function automatic stamp_t close_stamp();
		stamp_t r;
		longint y, m, d, era, yoe, doy, doe, e;
		r.st = ST_OK;
		r.secs = '0;
		if (pos < TS_LEN)
			r.st = ST_SHORT;
		else if (yr < lo_year || yr > hi_year)
			r.st = ST_YEAR;
		else if (mo < 1 || mo > 12 || dy < 1 || dy > 31)
			r.st = ST_DATE;
		else if (hr > 23 || mi > 59 || se > 59)
			r.st = ST_TIME;
		else begin
			y = longint'(yr);
			m = longint'(mo);
			d = longint'(dy);
			if (m <= 2)
				y = y - 1;
			era = (y >= 0 ? y : y - 399) / 400;
			yoe = y - era * 400;
			doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
			doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
			e = (era * 146097 + doe - 719468) * 86400 + longint'(hr) * 3600 +
				longint'(mi) * 60 + longint'(se);
			if (e <= 0)
				r.st = ST_EPOCH;
			else if (e > 64'sd4294967295)
				r.secs = 32'hFFFF_FFFF;
			else
				r.secs = 32'(e);
		end
		return r;
	endfunction

	function automatic bit track_char(input logic [7:0] c, input logic l, output stamp_t res);
		res.st = ST_OK;
		res.secs = '0;
		if (pos < TS_LEN) begin
			absorb(c);
			pos = pos + 5'd1;
		end
		if (!l)
			return 1'b0;
		res = close_stamp();
		clear_fields();
		return 1'b1;
	endfunction

	function automatic void log_miss(input string msg);
		miss_count++;
		if (miss_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic [7:0] odd_byte();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] sep_char(input logic [7:0] s);
		return ($urandom_range(0, 7) == 0) ? odd_byte() : s;
	endfunction

	function automatic void add_digits(input int unsigned v, input int unsigned n);
		int unsigned div;
		div = 1;
		repeat (n - 1) div = div * 10;
		repeat (n) begin
			stamp_text.push_back(8'(8'h30 + (v / div) % 10));
			div = div / 10;
		end
	endfunction

	function automatic void build_stamp();
		int unsigned roll, y, m, d, h, mn, s, n;
		roll = $urandom_range(0, 99);
		y = ($urandom_range(0, 9) < 8) ? $urandom_range(lo_year, hi_year)
			: $urandom_range(1960, 2110);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, 31);
		h = $urandom_range(0, 23);
		mn = $urandom_range(0, 59);
		s = $urandom_range(0, 59);
		if (roll >= 55 && roll < 67) begin
			case ($urandom_range(0, 5))
				0: y = $urandom_range(0, 9999);
				1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
				2: d = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
				3: h = $urandom_range(24, 99);
				4: mn = $urandom_range(60, 99);
				default: s = $urandom_range(60, 99);
			endcase
		end
		stamp_text.delete();
		add_digits(y, 4);
		stamp_text.push_back(sep_char("-"));
		add_digits(m, 2);
		stamp_text.push_back(sep_char("-"));
		add_digits(d, 2);
		stamp_text.push_back(sep_char(" "));
		add_digits(h, 2);
		stamp_text.push_back(sep_char(":"));
		add_digits(mn, 2);
		stamp_text.push_back(sep_char(":"));
		add_digits(s, 2);
		if (roll >= 67 && roll < 79) begin
			repeat ($urandom_range(1, 2)) stamp_text[$urandom_range(0, 18)] = odd_byte();
		end else if (roll >= 79 && roll < 87) begin
			n = $urandom_range(1, 18);
			while (stamp_text.size() > n) void'(stamp_text.pop_back());
		end else if (roll >= 87 && roll < 94) begin
			repeat ($urandom_range(1, 8)) stamp_text.push_back(odd_byte());
		end else if (roll >= 94) begin
			stamp_text.delete();
			repeat ($urandom_range(1, 30)) stamp_text.push_back(odd_byte());
		end
	endfunction

	task automatic put_beat(input logic [7:0] c, input logic l, input bit fixed,
			input status_t fst, input logic [31:0] fsecs);
		stamp_t want;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
		burst_left--;
		char_byte = c;
		last_char = l;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (track_char(c, l, want)) begin
			if (fixed) begin
				want.st = fst;
				want.secs = fsecs;
			end
			epoch_q.push_back(want);
		end
		@(negedge clk);
	endtask

	task automatic send_text(input bit fixed, input status_t fst, input logic [31:0] fsecs);
		for (int i = 0; i < stamp_text.size(); i++)
			put_beat(stamp_text[i], i == stamp_text.size() - 1, fixed, fst, fsecs);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [YEAR_CFG_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_MIN_YEAR)
			lo_year = val;
		else if (idx == REG_MAX_YEAR)
			hi_year = val;
		@(negedge clk);
	endtask

	task automatic set_years(input logic [YEAR_CFG_W-1:0] lo, input logic [YEAR_CFG_W-1:0] hi);
		in_valid = 1'b0;
		while (epoch_q.size() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
		write_reg(REG_MIN_YEAR, lo);
		write_reg(REG_MAX_YEAR, hi);
		cfg_valid = 1'b0;
	endtask

	// output side: stall pattern plus one long hold
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 80);
			end
			rx_left--;
			case (rx_mode)
				RX_FREE:   out_ready = 1'b1;
				RX_HALF:   out_ready = 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
				default:   out_ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (epoch_q.size() == 0) begin
				log_miss($sformatf("unexpected result: status %0d epoch %0d",
					status, epoch_seconds));
			end else begin
				front_stamp = epoch_q.pop_front();
				if (status !== front_stamp.st)
					log_miss($sformatf("status: expected %0d, got %0d",
						front_stamp.st, status));
				if (epoch_seconds !== front_stamp.secs)
					log_miss($sformatf("epoch_seconds: expected %0d, got %0d",
						front_stamp.secs, epoch_seconds));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timestamp_text_to_unix_epoch_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		logic [YEAR_CFG_W-1:0] lo, hi;
		int unsigned phase_start;
		wait (arst_n === 1'b1);
		@(negedge clk);
		for (int i = 0; i < N_CASES; i++) begin
			if (stamp_cases[i].lo_y != lo_year || stamp_cases[i].hi_y != hi_year)
				set_years(YEAR_CFG_W'(stamp_cases[i].lo_y), YEAR_CFG_W'(stamp_cases[i].hi_y));
			stamp_text.delete();
			for (int j = 0; j < stamp_cases[i].txt.len(); j++)
				stamp_text.push_back(stamp_cases[i].txt[j]);
			send_text(stamp_cases[i].fixed, stamp_cases[i].st, stamp_cases[i].secs);
		end
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < N_SET_PHASES) begin
				lo = YEAR_CFG_W'(phase_lo[ph]);
				hi = YEAR_CFG_W'(phase_hi[ph]);
			end else begin
				lo = YEAR_CFG_W'($urandom_range(1970, 2099));
				hi = YEAR_CFG_W'($urandom_range(lo, 2099));
			end
			set_years(lo, hi);
			if (ph == 1)
				hold_req = 1'b1;
			phase_start = beats_sent;
			while (beats_sent - phase_start < PHASE_BEATS) begin
				build_stamp();
				send_text(1'b0, ST_OK, '0);
			end
		end
		in_valid = 1'b0;
		while (epoch_q.size() != 0) @(negedge clk);
		repeat (END_PAUSE) @(negedge clk);
		if (miss_count == 0)
			$display("timestamp_text_to_unix_epoch_top: match");
		else
			$display("timestamp_text_to_unix_epoch_top: mismatch");
		$finish;
	end

endmodule

/* timestamp_text_to_unix_epoch_top.f */
+incdir+rtl
rtl/ttue_pkg.sv
rtl/ttue_front.sv
rtl/ttue_fifo.sv
rtl/ttue_back.sv
rtl/timestamp_text_to_unix_epoch_top.sv
verif/tb_top.sv
